[rtl/acvp_pkg.sv]
`timescale 1ns / 1ps

package acvp_pkg;

	localparam int MAX_LINE_CHARS      = 31;
	localparam int MAX_FRACTION_DIGITS = 9;

	localparam int LINE_LEN_W = $clog2(MAX_LINE_CHARS + 1);
	localparam int FRAC_W     = 4;
	localparam int MANT_W     = 32;
	localparam int Q_FRAC_W   = 16;
	localparam int VALUE_W    = 32;
	// 10^9 needs 30 bits
	localparam int DIVISOR_W  = 30;
	// mantissa << 16 plus half the divisor can carry into one more bit
	localparam int DIVIDEND_W = MANT_W + Q_FRAC_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_POINT = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [VALUE_W-1:0] VALUE_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] VALUE_NEG_MAX = 32'h8000_0000;

	function automatic logic [DIVISOR_W-1:0] pow10(input logic [FRAC_W-1:0] k);
		logic [DIVISOR_W-1:0] p;
		case (k)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			default: p = 30'd1000000000;
		endcase
		return p;
	endfunction

endpackage

[rtl/acvp_if.sv]
`timescale 1ns / 1ps

interface acvp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface acvp_res_if;
	logic                               valid;
	logic                               ready;
	logic [7:0]                         command;
	logic signed [acvp_pkg::VALUE_W-1:0] value_q16;
	logic                               saturated;

	modport source (output valid, output command, output value_q16, output saturated,
		input ready);
	modport sink   (input valid, input command, input value_q16, input saturated,
		output ready);
endinterface

[rtl/acvp_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module acvp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [acvp_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [acvp_pkg::DIVISOR_W-1:0]     divisor,
	output logic                               busy,
	output logic [acvp_pkg::DIVIDEND_W-1:0]    quotient
);
	import acvp_pkg::*;

	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIVIDEND_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// dividend bits shift out the top of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

[rtl/ascii_command_value_parser.sv]
`timescale 1ns / 1ps

// Line parser for "<command>[-]digits[.digits]" followed by CR or LF. Other
// bytes are taken while idle. A CR or LF that ends a non-empty line
// starts a bit-serial division of (mantissa << 16 + 10^k/2) by 10^k. The
// divider runs, S_DIV then sees it done and S_WRITE loads the result register,
// so a terminator holds the input off through S_DIV and S_WRITE, longer while the
// previous result still waits downstream; the single result register lets the
// next line's bytes be taken while a result waits. Empty lines give no result.
module ascii_command_value_parser (
	input  logic         clk,
	input  logic         arst_n,
	acvp_rx_if.sink      rx,
	acvp_res_if.source   res
);
	import acvp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_WRITE
	} state_t;

	state_t                 state_q;
	logic [LINE_LEN_W-1:0]  line_len_q;
	logic [7:0]             cmd_q;
	logic                   neg_q;
	logic                   point_q;
	logic [FRAC_W-1:0]      frac_q;
	logic [MANT_W-1:0]      mant_q;
	logic                   mant_sat_q;

	logic                   res_valid_q;
	logic [7:0]             res_cmd_q;
	logic [VALUE_W-1:0]     res_value_q;
	logic                   res_sat_q;

	logic                   accept;
	logic                   is_term;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [MANT_W+3:0]      mant_next;
	logic                   div_start;
	logic                   div_busy;
	logic [DIVIDEND_W-1:0]  dividend;
	logic [DIVISOR_W-1:0]   divisor;
	logic [DIVIDEND_W-1:0]  quotient;
	logic                   over;
	logic [VALUE_W-1:0]     value;
	logic                   out_free;

	assign rx.ready  = (state_q == S_IDLE);
	assign accept    = rx.valid && rx.ready;
	assign is_term   = (rx.rx_byte == CHAR_LF) || (rx.rx_byte == CHAR_CR);
	assign is_digit  = (rx.rx_byte >= CHAR_ZERO) && (rx.rx_byte <= CHAR_NINE);
	assign digit     = 4'(rx.rx_byte - CHAR_ZERO);
	// mantissa * 10 + digit as shift-add
	assign mant_next = {mant_q, 3'b000} + {3'b000, mant_q, 1'b0} + (MANT_W+4)'(digit);

	assign divisor   = pow10(frac_q);
	assign dividend  = {1'b0, mant_q, {Q_FRAC_W{1'b0}}}
		+ DIVIDEND_W'(divisor >> 1);
	assign div_start = accept && is_term && (line_len_q != '0);

	acvp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_comb begin
		if (neg_q) begin
			over  = quotient > DIVIDEND_W'(VALUE_NEG_MAX);
			value = '0 - (over ? VALUE_NEG_MAX : quotient[VALUE_W-1:0]);
		end else begin
			over  = quotient > DIVIDEND_W'(VALUE_POS_MAX);
			value = over ? VALUE_POS_MAX : quotient[VALUE_W-1:0];
		end
	end

	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			line_len_q  <= '0;
			cmd_q       <= '0;
			neg_q       <= 1'b0;
			point_q     <= 1'b0;
			frac_q      <= '0;
			mant_q      <= '0;
			mant_sat_q  <= 1'b0;
			res_valid_q <= 1'b0;
			res_cmd_q   <= '0;
			res_value_q <= '0;
			res_sat_q   <= 1'b0;
		end else begin
			// in S_WRITE the reload below covers a drained result
			if (res_valid_q && res.ready && state_q != S_WRITE) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_term) begin
							if (line_len_q != '0) begin
								state_q <= S_DIV;
							end
						end else if (line_len_q < LINE_LEN_W'(MAX_LINE_CHARS)) begin
							line_len_q <= line_len_q + 1'b1;
							if (line_len_q == '0) begin
								cmd_q <= rx.rx_byte;
							end else if (line_len_q == LINE_LEN_W'(1)
								&& rx.rx_byte == CHAR_MINUS) begin
								neg_q <= 1'b1;
							end else if (rx.rx_byte == CHAR_POINT) begin
								point_q <= 1'b1;
							end else if (is_digit
								&& (!point_q || frac_q < FRAC_W'(MAX_FRACTION_DIGITS))) begin
								if (point_q) begin
									frac_q <= frac_q + 1'b1;
								end
								if (mant_next[MANT_W+3:MANT_W] != '0) begin
									mant_q     <= '1;
									mant_sat_q <= 1'b1;
								end else begin
									mant_q <= mant_next[MANT_W-1:0];
								end
							end
						end
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_cmd_q   <= cmd_q;
						res_value_q <= value;
						res_sat_q   <= mant_sat_q || over;
						line_len_q  <= '0;
						cmd_q       <= '0;
						neg_q       <= 1'b0;
						point_q     <= 1'b0;
						frac_q      <= '0;
						mant_q      <= '0;
						mant_sat_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid     = res_valid_q;
	assign res.command   = res_cmd_q;
	assign res.value_q16 = res_value_q;
	assign res.saturated = res_sat_q;

endmodule
